/* rtl/cics_pkg.sv */
// -----------------------------------------------------------------------------
// cics_pkg
// Shared constants and types for the conditional inverse-CDF sampler.
// -----------------------------------------------------------------------------
`default_nettype none

package cics_pkg;

  localparam int TABLE_DEPTH_DEF    = 64;
  localparam int VALUE_BITS_DEF     = 32;
  localparam int PROB_FRAC_BITS_DEF = 16;

  localparam int IDX_BITS  = 6;
  localparam int TE_BITS   = 7;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [TE_BITS-1:0] TE_RESET = TE_BITS'(2);

  // register indexes
  localparam logic REG_TABLE_ENTRIES = 1'b0;

  // request kinds
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_PROB  = 2'd2
  } status_e;

  // bit position of the largest quotient magnitude passed on by the divider
  localparam int QSAT_BIT = 62;

endpackage

`default_nettype wire

/* rtl/cics_req_if.sv */
// -----------------------------------------------------------------------------
// cics_req_if
// Request channel: table writes and sample requests.
// -----------------------------------------------------------------------------
`default_nettype none

interface cics_req_if #(
  parameter int VALUE_BITS     = cics_pkg::VALUE_BITS_DEF,
  parameter int PROB_FRAC_BITS = cics_pkg::PROB_FRAC_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic        [cics_pkg::IDX_BITS-1:0] entry_index;
  logic signed [VALUE_BITS-1:0]        entry_value;
  logic        [PROB_FRAC_BITS:0]      entry_prob;
  logic signed [VALUE_BITS-1:0]        given_value;
  logic        [PROB_FRAC_BITS-1:0]    uniform_random;

  modport source (output valid, req_type, entry_index, entry_value, entry_prob,
                  given_value, uniform_random, input ready);
  modport sink   (input valid, req_type, entry_index, entry_value, entry_prob,
                  given_value, uniform_random, output ready);
endinterface

`default_nettype wire

/* rtl/cics_rsp_if.sv */
// -----------------------------------------------------------------------------
// cics_rsp_if
// Result channel: drawn value and status.
// -----------------------------------------------------------------------------
`default_nettype none

interface cics_rsp_if #(
  parameter int VALUE_BITS = cics_pkg::VALUE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic signed [VALUE_BITS-1:0] sample_value;
  logic        [1:0]      status;

  modport source (output valid, sample_value, status, input ready);
  modport sink   (input valid, sample_value, status, output ready);
endinterface

`default_nettype wire

/* rtl/cics_mem.sv */
// -----------------------------------------------------------------------------
// cics_mem
// Table store: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module cics_mem #(
  parameter int DEPTH = cics_pkg::TABLE_DEPTH_DEF,
  parameter int WIDTH = 49
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/cics_muldiv.sv */
// -----------------------------------------------------------------------------
// cics_muldiv
// Iterative a*b/c: shift-add multiply then restoring divide, one bit a cycle.
// -----------------------------------------------------------------------------
`default_nettype none

module cics_muldiv #(
  parameter int OPW = 34
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire signed [OPW-1:0]    a_i,
  input  wire signed [OPW-1:0]    b_i,
  input  wire signed [OPW-1:0]    c_i,
  output logic                    done_o,
  output logic signed [63:0]      q_o
);
  import cics_pkg::*;

  localparam int PW = 2 * OPW;
  localparam int CW = $clog2(PW + 1);
  localparam logic [PW+63:0] QLIM = (PW + 64)'(1) << QSAT_BIT;

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_DONE} mstate_e;

  mstate_e         state_q;
  logic            neg_q;
  logic [OPW-1:0]  cm_q;
  logic [OPW-1:0]  mplier_q;
  logic [PW-1:0]   mcand_q;
  logic [PW-1:0]   acc_q;
  logic [OPW-1:0]  rem_q;
  logic [PW-1:0]   dvd_q;
  logic [PW-1:0]   quo_q;
  logic [CW-1:0]   cnt_q;

  logic [PW-1:0]   acc_add;
  logic [OPW:0]    rem_sh;
  logic            ge;
  logic [OPW:0]    rem_sub;
  logic [PW+63:0]  qx;
  logic [62:0]     qmag;

  function automatic logic [OPW-1:0] mag(input logic signed [OPW-1:0] x);
    mag = x[OPW-1] ? OPW'(-x) : OPW'(x);
  endfunction

  always_comb begin
    acc_add = mplier_q[0] ? acc_q + mcand_q : acc_q;
    rem_sh  = {rem_q, dvd_q[PW-1]};
    ge      = rem_sh >= {1'b0, cm_q};
    rem_sub = rem_sh - {1'b0, cm_q};
    qx      = {64'b0, quo_q};
    qmag    = (qx > QLIM) ? QLIM[62:0] : qx[62:0];
    q_o     = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    done_o  = state_q == M_DONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            neg_q    <= a_i[OPW-1] ^ b_i[OPW-1] ^ c_i[OPW-1];
            mcand_q  <= PW'(mag(a_i));
            mplier_q <= mag(b_i);
            cm_q     <= mag(c_i);
            acc_q    <= '0;
            cnt_q    <= CW'(OPW);
            state_q  <= M_MUL;
          end
        end
        M_MUL: begin
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          cnt_q    <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            dvd_q   <= acc_add;
            rem_q   <= '0;
            quo_q   <= '0;
            cnt_q   <= CW'(PW);
            state_q <= M_DIV;
          end else begin
            acc_q <= acc_add;
          end
        end
        M_DIV: begin
          rem_q <= ge ? rem_sub[OPW-1:0] : rem_sh[OPW-1:0];
          dvd_q <= dvd_q << 1;
          quo_q <= {quo_q[PW-2:0], ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            state_q <= M_DONE;
          end
        end
        M_DONE: begin
          state_q <= M_IDLE;
        end
        default: begin
          state_q <= M_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/cics_ctrl.sv */
// -----------------------------------------------------------------------------
// cics_ctrl
// Sequencer: bounds check, up to two table searches, rescaling and result word.
// -----------------------------------------------------------------------------
`default_nettype none

module cics_ctrl #(
  parameter int TABLE_DEPTH    = cics_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_BITS     = cics_pkg::VALUE_BITS_DEF,
  parameter int PROB_FRAC_BITS = cics_pkg::PROB_FRAC_BITS_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire  [cics_pkg::TE_BITS-1:0]  table_entries_i,
  cics_req_if.sink                      req_i,
  cics_rsp_if.source                    rsp_o
);
  import cics_pkg::*;

  localparam int VB  = VALUE_BITS;
  localparam int PF  = PROB_FRAC_BITS;
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int NW  = $clog2(TABLE_DEPTH + 1);
  localparam int MW  = VB + PF + 1;
  localparam int OPW = ((VB > PF + 1) ? VB : PF + 1) + 1;
  localparam logic [PF:0] ONE = (PF + 1)'(1) << PF;
  localparam logic signed [65:0] VMAX = (66'(1) << (VB - 1)) - 66'(1);
  localparam logic signed [65:0] VMIN = -VMAX - 66'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RDN, S_LOC, S_LOCW, S_RDI, S_RDI1, S_MD,
    S_RSCALE, S_RADD, S_RES, S_DONE
  } state_e;

  state_e                state_q;
  logic                  phase_q;   // 0 value search, 1 probability search
  logic [NW-1:0]         n_q, b_q, cnt_q;
  logic signed [VB-1:0]  g_q, v0_q, vi_q;
  logic [PF-1:0]         u_q;
  logic [PF:0]           p0_q, pi_q, p_q, r_q;
  logic [2*PF:0]         prod_q;
  logic signed [63:0]    d_q;
  logic signed [VB-1:0]  res_q;
  status_e               st_q;
  logic                  rsp_valid_q;
  logic signed [VB-1:0]  rsp_value_q;
  status_e               rsp_status_q;

  logic                  md_start, md_done;
  logic signed [OPW-1:0] md_a, md_b, md_c;
  logic signed [63:0]    md_q;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [MW-1:0]         mem_rdata;
  logic signed [VB-1:0]  rd_v;
  logic [PF:0]           rd_p;

  logic                  acc;
  logic                  rsp_load;
  logic [NW-1:0]         n_clamp, m, probe;
  logic                  key_lt;
  logic signed [OPW-1:0] dv_x, dp_x;
  logic signed [64:0]    psum;
  logic signed [65:0]    rsum;

  assign rd_v = mem_rdata[MW-1:PF+1];
  assign rd_p = mem_rdata[PF:0];
  assign acc  = req_i.valid && req_i.ready;
  // output register frees up when the held word is taken
  assign rsp_load = state_q == S_DONE && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    if (int'(table_entries_i) < 2) begin
      n_clamp = NW'(2);
    end else if (int'(table_entries_i) > TABLE_DEPTH) begin
      n_clamp = NW'(TABLE_DEPTH);
    end else begin
      n_clamp = NW'(table_entries_i);
    end
    m      = (cnt_q >> 1) + NW'(cnt_q[0]);
    probe  = b_q + m - NW'(1);
    key_lt = phase_q ? (r_q < rd_p) : (g_q < rd_v);
    dv_x   = OPW'(rd_v) - OPW'(vi_q);
    dp_x   = OPW'($signed({1'b0, rd_p})) - OPW'($signed({1'b0, pi_q}));
    psum   = 65'($signed({1'b0, pi_q})) + 65'(md_q);
    rsum   = 66'(vi_q) - 66'(g_q) + 66'(d_q);

    mem_we    = acc && req_i.req_type == REQ_WRITE && int'(req_i.entry_index) < TABLE_DEPTH;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_q)
      S_IDLE: begin
        mem_re = acc && req_i.req_type == REQ_SAMPLE;
      end
      S_RD0: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(n_q - NW'(1));
      end
      S_LOC: begin
        mem_re    = 1'b1;
        mem_raddr = (m <= NW'(1)) ? AW'(b_q) : AW'(probe);
      end
      S_RDI: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(b_q + NW'(1));
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase

    md_start = state_q == S_RDI1 &&
               (phase_q ? dp_x != '0 : dv_x != '0);
    if (!phase_q) begin
      md_a = OPW'(g_q) - OPW'(vi_q);
      md_b = dp_x;
      md_c = dv_x;
    end else begin
      md_a = OPW'($signed({1'b0, r_q})) - OPW'($signed({1'b0, pi_q}));
      md_b = dv_x;
      md_c = dp_x;
    end
  end

  assign req_i.ready        = state_q == S_IDLE;
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.sample_value = rsp_value_q;
  assign rsp_o.status       = rsp_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc && req_i.req_type == REQ_SAMPLE) begin
            g_q     <= req_i.given_value;
            u_q     <= req_i.uniform_random;
            n_q     <= n_clamp;
            state_q <= S_RD0;
          end
        end
        S_RD0: begin
          v0_q    <= rd_v;
          p0_q    <= rd_p;
          state_q <= S_RDN;
        end
        S_RDN: begin
          b_q   <= '0;
          cnt_q <= n_q;
          res_q <= '0;
          if (v0_q > g_q || rd_v < g_q) begin
            phase_q <= 1'b0;
            st_q    <= STATUS_RANGE;
            state_q <= S_DONE;
          end else if (p0_q != '0 || rd_p != ONE) begin
            phase_q <= 1'b0;
            st_q    <= STATUS_PROB;
            state_q <= S_DONE;
          end else if (g_q == v0_q) begin
            r_q     <= (PF + 1)'(u_q);
            phase_q <= 1'b1;
            st_q    <= STATUS_OK;
            state_q <= S_LOC;
          end else if (g_q >= rd_v) begin
            p_q     <= rd_p;
            phase_q <= 1'b0;
            st_q    <= STATUS_OK;
            state_q <= S_RSCALE;
          end else begin
            phase_q <= 1'b0;
            st_q    <= STATUS_OK;
            state_q <= S_LOC;
          end
        end
        S_LOC: begin
          state_q <= (m <= NW'(1)) ? S_RDI : S_LOCW;
        end
        S_LOCW: begin
          if (key_lt) begin
            cnt_q <= m;
          end else begin
            b_q   <= probe;
            cnt_q <= cnt_q - m + NW'(1);
          end
          state_q <= S_LOC;
        end
        S_RDI: begin
          vi_q    <= rd_v;
          pi_q    <= rd_p;
          state_q <= S_RDI1;
        end
        S_RDI1: begin
          if (md_start) begin
            state_q <= S_MD;
          end else if (!phase_q) begin
            // flat value step: full weight, still capped at one
            p_q     <= (rd_p > ONE) ? ONE : rd_p;
            state_q <= S_RSCALE;
          end else begin
            d_q     <= 64'(dv_x);
            state_q <= S_RES;
          end
        end
        S_MD: begin
          if (md_done) begin
            if (!phase_q) begin
              if (psum[64]) begin
                p_q <= '0;
              end else if (psum > 65'($signed({1'b0, ONE}))) begin
                p_q <= ONE;
              end else begin
                p_q <= psum[PF:0];
              end
              state_q <= S_RSCALE;
            end else begin
              d_q     <= md_q;
              state_q <= S_RES;
            end
          end
        end
        S_RSCALE: begin
          prod_q  <= (2 * PF + 1)'(u_q) * (2 * PF + 1)'(ONE - p_q);
          state_q <= S_RADD;
        end
        S_RADD: begin
          r_q     <= p_q + prod_q[2*PF:PF];
          phase_q <= 1'b1;
          b_q     <= '0;
          cnt_q   <= n_q;
          state_q <= S_LOC;
        end
        S_RES: begin
          if (rsum > VMAX) begin
            res_q <= VMAX[VB-1:0];
          end else if (rsum < VMIN) begin
            res_q <= VMIN[VB-1:0];
          end else begin
            res_q <= rsum[VB-1:0];
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp_value_q  <= res_q;
            rsp_status_q <= st_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  cics_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (MW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(req_i.entry_index)),
    .wdata_i ({req_i.entry_value, req_i.entry_prob}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cics_muldiv #(
    .OPW (OPW)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (md_a),
    .b_i     (md_b),
    .c_i     (md_c),
    .done_o  (md_done),
    .q_o     (md_q)
  );

endmodule

`default_nettype wire

/* rtl/conditional_inverse_cdf_sampler.sv */
// -----------------------------------------------------------------------------
// conditional_inverse_cdf_sampler
// Inverse transform sampling over a piecewise-linear CDF, above a given value.
// -----------------------------------------------------------------------------
// A table write goes to the table store when its request is accepted. A sample
// that fails a check ends without a table search. Each table search step is
// one read of the table store, and each interpolation runs a bit-serial
// multiply then divide. Items are handled one at a time; a finished word waits
// in the output register while the next item is taken. Table entries must be
// written before a sample reads them.
`default_nettype none

module conditional_inverse_cdf_sampler #(
  parameter int TABLE_DEPTH    = cics_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_BITS     = cics_pkg::VALUE_BITS_DEF,
  parameter int PROB_FRAC_BITS = cics_pkg::PROB_FRAC_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  cics_req_if.sink                     req_i,
  cics_rsp_if.source                   rsp_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [cics_pkg::APB_AW-1:0]  paddr,
  input  wire  [cics_pkg::APB_DW-1:0]  pwdata,
  output logic [cics_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import cics_pkg::*;

  logic [TE_BITS-1:0] te_q;
  logic               sel_te;

  assign sel_te = paddr[2] == REG_TABLE_ENTRIES;
  assign pready = 1'b1;
  assign prdata = sel_te ? APB_DW'(te_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      te_q <= TE_RESET;
    end else if (psel && penable && pwrite && sel_te) begin
      te_q <= pwdata[TE_BITS-1:0];
    end
  end

  cics_ctrl #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .VALUE_BITS     (VALUE_BITS),
    .PROB_FRAC_BITS (PROB_FRAC_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .table_entries_i (te_q),
    .req_i           (req_i),
    .rsp_o           (rsp_o)
  );

endmodule

`default_nettype wire
